// ===== hdl/smau_pkg.sv =====
// Shared types and codes for the stack machine arithmetic unit.
package smau_pkg;

    localparam int WORD_W   = 32;
    localparam int ACTION_W = 3;
    localparam int STATUS_W = 2;
    localparam int DEPTH_W  = 11;

    localparam logic [ACTION_W-1:0] ACT_PUSH = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_ADD  = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_SUB  = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_DIV  = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_MUL  = 3'd4;
    localparam logic [ACTION_W-1:0] ACT_NOP  = 3'd5;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_SHORT   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_DIVZERO = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd3;

    typedef struct packed {
        logic [ACTION_W-1:0]      action;
        logic signed [WORD_W-1:0] push_value;
    } req_t;

    typedef struct packed {
        logic [STATUS_W-1:0]      status;
        logic signed [WORD_W-1:0] top_value;
        logic [DEPTH_W-1:0]       depth;
    } rsp_t;

endpackage

// ===== hdl/smau_div.sv =====
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
module smau_div
    import smau_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [WORD_W-1:0] dividend,
    input  logic [WORD_W-1:0] divisor,
    output logic              done,
    output logic [WORD_W-1:0] quotient
);

    localparam int CNT_W = $clog2(WORD_W + 1);

    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              done_reg, done_next;
    logic [WORD_W-1:0] rem_reg, rem_next;
    logic [WORD_W-1:0] quo_reg, quo_next;
    logic [WORD_W-1:0] den_reg, den_next;
    logic              neg_reg, neg_next;
    logic [WORD_W:0]   rem_shift;
    logic [WORD_W:0]   diff;

    assign rem_shift = {rem_reg, quo_reg[WORD_W-1]};
    assign diff      = rem_shift - {1'b0, den_reg};

    always_comb
    begin
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        neg_next  = neg_reg;
        if (start)
        begin
            // Work on magnitudes; the most negative value maps to 2^31 unsigned.
            rem_next = '0;
            quo_next = dividend[WORD_W-1] ? (~dividend + 1'b1) : dividend;
            den_next = divisor[WORD_W-1] ? (~divisor + 1'b1) : divisor;
            neg_next = dividend[WORD_W-1] ^ divisor[WORD_W-1];
            cnt_next = CNT_W'(WORD_W);
        end
        else if (cnt_reg != '0)
        begin
            if (!diff[WORD_W])
            begin
                rem_next = diff[WORD_W-1:0];
                quo_next = {quo_reg[WORD_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_shift[WORD_W-1:0];
                quo_next = {quo_reg[WORD_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
        neg_reg <= neg_next;
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? (~quo_reg + 1'b1) : quo_reg;

endmodule

// ===== hdl/stack_machine_arith_unit.sv =====
// Stack machine arithmetic unit: stack in a synchronous memory, one request at a time.
// Push, nop, too short and stack full go from S_IDLE to S_DONE; add, sub, mul and a
// zero divisor pass through S_OPER; div also waits in S_DIVW on the one-bit-per-cycle
// divider. A new request is taken the cycle after the previous result moves into the
// output register; a result still waiting there holds the next one back.
// Reset clears the count and handshake state at once; only pushed entries are ever used.
module stack_machine_arith_unit
    import smau_pkg::*;
#(
    parameter int STACK_DEPTH = 1024
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_ready,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_ready,
    output rsp_t rsp
);

    // Count width holds STACK_DEPTH itself; address width indexes the memory.
    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam logic [CW-1:0] DEPTH_FULL = CW'(STACK_DEPTH);

    // Sequencer states.
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_OPER = 3'd1;
    localparam logic [2:0] S_DIVW = 3'd2;
    localparam logic [2:0] S_DONE = 3'd3;

    logic [2:0]          state_reg, state_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [WORD_W-1:0]   top_reg, top_next;
    logic [STATUS_W-1:0] st_reg, st_next;
    logic [ACTION_W-1:0] act_reg, act_next;
    logic                rsp_valid_reg, rsp_valid_next;
    rsp_t                rsp_reg, rsp_next;

    // The stack store. Entry count-1 is mirrored in top_reg so only the
    // second entry ever has to be read back.
    logic [WORD_W-1:0] mem [STACK_DEPTH];
    logic [WORD_W-1:0] rd_data_reg;
    logic [CW-1:0]     sec_idx;
    logic [AW-1:0]     rd_addr;
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [WORD_W-1:0] wr_data;

    logic              div_start;
    logic              div_done;
    logic [WORD_W-1:0] div_quo;
    logic              accept;

    assign sec_idx = count_reg - CW'(2);
    assign rd_addr = sec_idx[AW-1:0];
    assign accept  = req_valid && req_ready;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    smau_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (rd_data_reg),
        .divisor  (top_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        top_next       = top_reg;
        st_next        = st_reg;
        act_next       = act_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        wr_en          = 1'b0;
        wr_addr        = rd_addr;
        wr_data        = '0;
        div_start      = 1'b0;

        // The output register empties when its result is taken.
        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    st_next    = ST_OK;
                    act_next   = req.action;
                    state_next = S_DONE;
                    unique case (req.action)
                        ACT_PUSH:
                        begin
                            if (count_reg >= DEPTH_FULL)
                            begin
                                st_next = ST_FULL;
                            end
                            else
                            begin
                                wr_en      = 1'b1;
                                wr_addr    = count_reg[AW-1:0];
                                wr_data    = req.push_value;
                                top_next   = req.push_value;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        ACT_ADD, ACT_SUB, ACT_DIV, ACT_MUL:
                        begin
                            // The second entry is read this cycle and ready in S_OPER.
                            if (count_reg < CW'(2))
                            begin
                                st_next = ST_SHORT;
                            end
                            else
                            begin
                                state_next = S_OPER;
                            end
                        end
                        default:
                        begin
                            // Nop and the unused codes leave the stack alone.
                            st_next = ST_OK;
                        end
                    endcase
                end
            end
            S_OPER:
            begin
                state_next = S_DONE;
                unique case (act_reg)
                    ACT_ADD:
                    begin
                        wr_en      = 1'b1;
                        wr_data    = rd_data_reg + top_reg;
                        top_next   = wr_data;
                        count_next = count_reg - 1'b1;
                    end
                    ACT_SUB:
                    begin
                        wr_en      = 1'b1;
                        wr_data    = rd_data_reg - top_reg;
                        top_next   = wr_data;
                        count_next = count_reg - 1'b1;
                    end
                    ACT_MUL:
                    begin
                        // Low word of the product; it lands in registers right away.
                        wr_en      = 1'b1;
                        wr_data    = rd_data_reg * top_reg;
                        top_next   = wr_data;
                        count_next = count_reg - 1'b1;
                    end
                    ACT_DIV:
                    begin
                        if (top_reg == '0)
                        begin
                            st_next = ST_DIVZERO;
                        end
                        else
                        begin
                            div_start  = 1'b1;
                            state_next = S_DIVW;
                        end
                    end
                    default:
                    begin
                        st_next = ST_OK;
                    end
                endcase
            end
            S_DIVW:
            begin
                // rd_data_reg still holds the second entry: the read address
                // does not move while the count is unchanged.
                if (div_done)
                begin
                    wr_en      = 1'b1;
                    wr_data    = div_quo;
                    top_next   = div_quo;
                    count_next = count_reg - 1'b1;
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_next.status    = st_reg;
                    rsp_next.top_value = (count_reg != '0) ? top_reg : '0;
                    rsp_next.depth     = DEPTH_W'(count_reg);
                    rsp_valid_next     = 1'b1;
                    state_next         = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        top_reg <= top_next;
        st_reg  <= st_next;
        act_reg <= act_next;
        rsp_reg <= rsp_next;
    end

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the stack machine arithmetic unit.
module tb_top;
    import smau_pkg::*;

    // The stack depth matches the block's default, so that filling the stack is affordable.
    localparam int STACK_DEPTH = 1024;

    // Action codes 6 and 7 are not assigned. The block must treat them as a nop.
    localparam logic [ACTION_W-1:0] ACT_SPARE6 = 3'd6;
    localparam logic [ACTION_W-1:0] ACT_SPARE7 = 3'd7;

    localparam logic signed [WORD_W-1:0] WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};
    localparam logic signed [WORD_W-1:0] WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};
    localparam logic signed [WORD_W-1:0] WORD_NEG1 = '1;

    // The longest silence on both channels that a correct run can show, with wide margin.
    // A divide is the slowest request, and stalls on either side lengthen it.
    localparam int HANG_LIMIT = 3000;
    // After the last result, allow a divide's latency for any stray response to show up.
    localparam int TAIL_CYCLES = 40;
    localparam int RANDOM_TOTAL = 1430;
    localparam int WARMUP_ITEMS = 200;
    localparam int FULL_PROBE_ITEMS = 12;
    localparam int STEADY_ITEMS = 400;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_ready;
    req_t req = '0;
    logic rsp_valid;
    logic rsp_ready = 1'b0;
    rsp_t rsp;

    stack_machine_arith_unit #(
        .STACK_DEPTH(STACK_DEPTH)
    ) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .req_valid(req_valid),
        .req_ready(req_ready),
        .req(req),
        .rsp_valid(rsp_valid),
        .rsp_ready(rsp_ready),
        .rsp(rsp)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // One row of the directed script. When has_want is set, the expected response is the
    // typed-in value; otherwise the predictor supplies it.
    typedef struct packed {
        req_t item;
        logic has_want;
        rsp_t want;
    } script_row_t;

    // The opening script walks through the empty stack, wrap-around on add, the one
    // divide that overflows, a zero divisor, the unassigned action codes, a subtract
    // and a multiply that wrap, and a few ordinary operations.
    localparam int SCRIPT_LEN = 23;
    localparam script_row_t SCRIPT [SCRIPT_LEN] = '{
        '{'{ACT_ADD, 32'sd0}, 1'b1, '{ST_SHORT, 32'sd0, 11'd0}},
        '{'{ACT_DIV, 32'sd0}, 1'b1, '{ST_SHORT, 32'sd0, 11'd0}},
        '{'{ACT_NOP, WORD_MIN}, 1'b1, '{ST_OK, 32'sd0, 11'd0}},
        '{'{ACT_PUSH, WORD_MAX}, 1'b1, '{ST_OK, WORD_MAX, 11'd1}},
        '{'{ACT_MUL, WORD_NEG1}, 1'b1, '{ST_SHORT, WORD_MAX, 11'd1}},
        '{'{ACT_SUB, 32'sd5}, 1'b1, '{ST_SHORT, WORD_MAX, 11'd1}},
        '{'{ACT_PUSH, 32'sd1}, 1'b1, '{ST_OK, 32'sd1, 11'd2}},
        '{'{ACT_ADD, 32'sd0}, 1'b1, '{ST_OK, WORD_MIN, 11'd1}},
        '{'{ACT_PUSH, WORD_NEG1}, 1'b1, '{ST_OK, WORD_NEG1, 11'd2}},
        '{'{ACT_DIV, 32'sd0}, 1'b1, '{ST_OK, WORD_MIN, 11'd1}},
        '{'{ACT_PUSH, 32'sd0}, 1'b1, '{ST_OK, 32'sd0, 11'd2}},
        '{'{ACT_DIV, WORD_MAX}, 1'b1, '{ST_DIVZERO, 32'sd0, 11'd2}},
        '{'{ACT_SPARE6, WORD_NEG1}, 1'b1, '{ST_OK, 32'sd0, 11'd2}},
        '{'{ACT_SPARE7, WORD_MAX}, 1'b1, '{ST_OK, 32'sd0, 11'd2}},
        '{'{ACT_SUB, 32'sd0}, 1'b1, '{ST_OK, WORD_MIN, 11'd1}},
        '{'{ACT_PUSH, WORD_MIN}, 1'b1, '{ST_OK, WORD_MIN, 11'd2}},
        '{'{ACT_MUL, 32'sd0}, 1'b1, '{ST_OK, 32'sd0, 11'd1}},
        '{'{ACT_PUSH, -32'sd7}, 1'b0, '0},
        '{'{ACT_PUSH, 32'sd2}, 1'b0, '0},
        '{'{ACT_DIV, 32'sd0}, 1'b0, '0},
        '{'{ACT_PUSH, WORD_MAX}, 1'b0, '0},
        '{'{ACT_SUB, 32'sd0}, 1'b0, '0},
        '{'{ACT_MUL, 32'sd0}, 1'b0, '0}
    };

    // The testbench's own copy of the stack. Entries at or above stack_len are never read.
    logic signed [WORD_W-1:0] stack_words [STACK_DEPTH];
    int unsigned stack_len = 0;

    // Responses still owed by the block, oldest first.
    rsp_t owed_responses [$];
    int mismatches = 0;
    int idle_cycles = 0;

    // While steady is set, neither side inserts idle cycles.
    bit steady = 1'b0;

    // Applies one request to the stack copy and returns the response the block must give.
    function automatic rsp_t stack_step(input req_t item);
        rsp_t out;
        logic signed [WORD_W-1:0] second;
        logic signed [WORD_W-1:0] top;
        logic signed [WORD_W-1:0] outcome;
        out = '0;
        out.status = ST_OK;
        case (item.action)
            ACT_PUSH:
            begin
                if (stack_len >= STACK_DEPTH)
                begin
                    out.status = ST_FULL;
                end
                else
                begin
                    stack_words[stack_len] = item.push_value;
                    stack_len++;
                end
            end
            ACT_ADD, ACT_SUB, ACT_DIV, ACT_MUL:
            begin
                if (stack_len < 2)
                begin
                    out.status = ST_SHORT;
                end
                else
                begin
                    top = stack_words[stack_len-1];
                    second = stack_words[stack_len-2];
                    outcome = '0;
                    case (item.action)
                        ACT_ADD: outcome = second + top;
                        ACT_SUB: outcome = second - top;
                        ACT_MUL: outcome = second * top;
                        default:
                        begin
                            // Division truncates toward zero. The one quotient that does
                            // not fit wraps back to the most negative value.
                            if (top == 0)
                                out.status = ST_DIVZERO;
                            else if (second == WORD_MIN && top == WORD_NEG1)
                                outcome = WORD_MIN;
                            else
                                outcome = second / top;
                        end
                    endcase
                    if (out.status == ST_OK)
                    begin
                        stack_words[stack_len-2] = outcome;
                        stack_len--;
                    end
                end
            end
            default:
            begin
                // Nop and the unassigned codes leave the stack alone.
            end
        endcase
        out.top_value = (stack_len > 0) ? stack_words[stack_len-1] : '0;
        out.depth = stack_len[DEPTH_W-1:0];
        return out;
    endfunction

    // Operand values lean toward the corners of signed arithmetic: zero, one, minus one,
    // the two extremes and small numbers, so that zero divisors and overflow come up often.
    function automatic logic signed [WORD_W-1:0] pick_word();
        int unsigned choice;
        choice = $urandom_range(15);
        case (choice)
            0: return '0;
            1: return 32'sd1;
            2: return WORD_NEG1;
            3: return WORD_MIN;
            4: return WORD_MAX;
            5, 6, 7: return $signed($urandom_range(30)) - 32'sd15;
            default: return $urandom();
        endcase
    endfunction

    // Picks a push with the given percentage. Otherwise it picks an arithmetic operation
    // most of the time, and now and then a nop or one of the unassigned codes.
    function automatic logic [ACTION_W-1:0] pick_action(input int unsigned push_pct);
        int unsigned choice;
        if ($urandom_range(99) < push_pct)
            return ACT_PUSH;
        choice = $urandom_range(19);
        if (choice < 4)
            return ACT_ADD;
        if (choice < 8)
            return ACT_SUB;
        if (choice < 12)
            return ACT_DIV;
        if (choice < 16)
            return ACT_MUL;
        if (choice == 16)
            return ACT_NOP;
        if (choice == 17)
            return ACT_SPARE6;
        if (choice == 18)
            return ACT_SPARE7;
        return ACT_NOP;
    endfunction

    // Presents one request and returns once the block has taken it. A random gap may come
    // first. When there is no gap, valid simply stays high from the previous request.
    task automatic send_request(input req_t item);
        while (!steady && $urandom_range(99) < 6)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req <= item;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
    endtask

    // Sends a request and files the response it must cause. A typed-in expectation, where
    // given, takes the place of the predicted one, but the stack copy still moves on.
    task automatic issue(input req_t item, input bit has_want, input rsp_t want);
        rsp_t predicted;
        send_request(item);
        predicted = stack_step(item);
        owed_responses.push_back(has_want ? want : predicted);
    endtask

    task automatic issue_random(input int unsigned push_pct);
        req_t item;
        item.action = pick_action(push_pct);
        item.push_value = pick_word();
        issue(item, 1'b0, '0);
    endtask

    // Holds the sender back until every owed response has arrived. The task
    // always waits on the clock first, so valid is never lowered and raised in the same step.
    task automatic wait_for_responses();
        req_valid <= 1'b0;
        @(posedge clk);
        while (owed_responses.size() != 0)
            @(posedge clk);
    endtask

    // The receiver stalls about six percent of the time outside the steady stretch.
    always @(posedge clk)
    begin
        rsp_ready <= steady || ($urandom_range(99) >= 6);
    end

    // Every response taken is compared field by field with the oldest one owed.
    always @(posedge clk)
    begin
        rsp_t owed;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (owed_responses.size() == 0)
            begin
                $error("response with none owed: status %0d top_value %0d depth %0d",
                       rsp.status, rsp.top_value, rsp.depth);
                mismatches++;
            end
            else
            begin
                owed = owed_responses.pop_front();
                if (rsp.status !== owed.status)
                begin
                    $error("status: expected %0d, actual %0d", owed.status, rsp.status);
                    mismatches++;
                end
                if (rsp.top_value !== owed.top_value)
                begin
                    $error("top_value: expected %0d, actual %0d",
                           owed.top_value, rsp.top_value);
                    mismatches++;
                end
                if (rsp.depth !== owed.depth)
                begin
                    $error("depth: expected %0d, actual %0d", owed.depth, rsp.depth);
                    mismatches++;
                end
            end
        end
    end

    // The watchdog ends a run in which neither channel moves for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= HANG_LIMIT)
            begin
                $display("stack_machine_arith_unit: mismatch");
                $finish;
            end
        end
    end

    initial
    begin
        int random_count;
        int fill_count;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // The directed script runs first, straight after reset with an empty stack.
        for (int row = 0; row < SCRIPT_LEN; row++)
            issue(SCRIPT[row].item, SCRIPT[row].has_want, SCRIPT[row].want);
        wait_for_responses();

        // A warm-up with pushes and operations in about equal measure keeps the stack
        // shallow, so that too-short errors keep turning up among the ordinary results.
        random_count = 0;
        while (random_count < WARMUP_ITEMS)
        begin
            issue_random(45);
            random_count++;
        end
        wait_for_responses();

        // Now fill the stack to the top. The first part of the fill runs without any idle
        // cycles on either side, to show that the block keeps up back to back.
        steady = 1'b1;
        fill_count = 0;
        while (stack_len < STACK_DEPTH)
        begin
            if (fill_count == STEADY_ITEMS)
                steady = 1'b0;
            issue_random(96);
            random_count++;
            fill_count++;
        end
        steady = 1'b0;

        // With the stack full, further pushes must be refused with the full status.
        repeat (FULL_PROBE_ITEMS)
        begin
            issue_random(75);
            random_count++;
        end

        // The rest mostly pops, working through deep entries that were written long ago.
        while (random_count < RANDOM_TOTAL)
        begin
            issue_random(35);
            random_count++;
        end

        wait_for_responses();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("stack_machine_arith_unit: match");
        else
            $display("stack_machine_arith_unit: mismatch");
        $finish;
    end

endmodule

// ===== files.f =====
hdl/smau_pkg.sv
hdl/smau_div.sv
hdl/stack_machine_arith_unit.sv
tb/tb_top.sv
